// ----- hw/rtl/rchash_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rchash_pkg: shared types and constants
// Operation codes, status codes and sequencer states of the user table.
// ----------------------------------------------------------------------------
package rchash_pkg;

   localparam int HASH_SHIFT = 8;

   typedef enum logic [1:0] {
      FN_FIND   = 2'd0,
      FN_ALLOC  = 2'd1,
      FN_FREE   = 2'd2,
      FN_SWITCH = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STAT_FOUND    = 3'd0,
      STAT_INSERTED = 3'd1,
      STAT_ABSENT   = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_REMOVED  = 3'd4,
      STAT_HELD     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CAP1,
      ST_CAP2,
      ST_EXEC,
      ST_EXEC2
   } eng_state_type;

endpackage

// ----- hw/rtl/rchash_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rchash_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rchash_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hw/rtl/rchash_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rchash_front: request intake
// Hash both IDs of each request and hold it in a two-entry queue.
// ----------------------------------------------------------------------------
module rchash_front
   import rchash_pkg::*;
#(
   parameter int HASH_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [1:0]           func,
   input  logic [31:0]          uid,
   input  logic [31:0]          old_uid,
   output logic                 full,
   output logic                 item_valid,
   input  logic                 item_take,
   output func_type             item_func,
   output logic [31:0]          item_uid,
   output logic [31:0]          item_old_uid,
   output logic [HASH_BITS-1:0] item_bkt_new,
   output logic [HASH_BITS-1:0] item_bkt_old
);

   logic [31:0]          sum_new, sum_old;
   func_type             func_ff     [2];
   logic [31:0]          uid_ff      [2];
   logic [31:0]          old_ff      [2];
   logic [HASH_BITS-1:0] bkt_new_ff  [2];
   logic [HASH_BITS-1:0] bkt_old_ff  [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           cnt_ff, cnt_in;

   // bucket = low HASH_BITS bits of ((id >> 8) + id), sum wrapping at 32 bits
   assign sum_new = (uid >> HASH_SHIFT) + uid;
   assign sum_old = (old_uid >> HASH_SHIFT) + old_uid;

   assign full       = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);

   assign item_func    = func_ff[rd_ptr_ff];
   assign item_uid     = uid_ff[rd_ptr_ff];
   assign item_old_uid = old_ff[rd_ptr_ff];
   assign item_bkt_new = bkt_new_ff[rd_ptr_ff];
   assign item_bkt_old = bkt_old_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ (push & ~full);
      rd_ptr_in = rd_ptr_ff ^ (item_take & item_valid);
      cnt_in    = cnt_ff + {1'b0, push & ~full} - {1'b0, item_take & item_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         func_ff[wr_ptr_ff]    <= func_type'(func);
         uid_ff[wr_ptr_ff]     <= uid;
         old_ff[wr_ptr_ff]     <= old_uid;
         bkt_new_ff[wr_ptr_ff] <= sum_new[HASH_BITS-1:0];
         bkt_old_ff[wr_ptr_ff] <= sum_old[HASH_BITS-1:0];
      end
   end

endmodule

// ----- hw/rtl/rchash_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rchash_back: table engine
// Clear the table, ID 0 preset in bucket 0, then read, update and write rows.
// ----------------------------------------------------------------------------
module rchash_back
   import rchash_pkg::*;
#(
   parameter int HASH_BITS  = 8,
   parameter int WAYS       = 4,
   parameter int COUNT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_take,
   input  func_type             item_func,
   input  logic [31:0]          item_uid,
   input  logic [31:0]          item_old_uid,
   input  logic [HASH_BITS-1:0] item_bkt_new,
   input  logic [HASH_BITS-1:0] item_bkt_old,
   output logic                 clearing,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [2:0]           rsp_status,
   output logic [15:0]          rsp_ref_count,
   output logic [15:0]          rsp_process_count
);

   localparam int BUCKETS = 1 << HASH_BITS;
   localparam int EW      = 1 + 32 + 2 * COUNT_BITS;
   localparam int RW      = EW * WAYS;
   localparam int WB      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CB      = COUNT_BITS;

   function automatic logic ent_valid(logic [RW-1:0] row, logic [WB-1:0] idx);
      return row[idx * EW + EW - 1];
   endfunction

   function automatic logic [31:0] ent_id(logic [RW-1:0] row, logic [WB-1:0] idx);
      return row[idx * EW + 2 * CB +: 32];
   endfunction

   function automatic logic [CB-1:0] ent_ref(logic [RW-1:0] row, logic [WB-1:0] idx);
      return row[idx * EW + CB +: CB];
   endfunction

   function automatic logic [CB-1:0] ent_proc(logic [RW-1:0] row, logic [WB-1:0] idx);
      return row[idx * EW +: CB];
   endfunction

   function automatic logic [RW-1:0] ent_set(logic [RW-1:0] row, logic [WB-1:0] idx,
                                             logic v, logic [31:0] id,
                                             logic [CB-1:0] r, logic [CB-1:0] p);
      logic [RW-1:0] res;
      res = row;
      res[idx * EW +: EW] = {v, id, r, p};
      return res;
   endfunction

   function automatic logic [CB-1:0] inc_sat(logic [CB-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [CB-1:0] dec_sat(logic [CB-1:0] v);
      return (v == '0) ? v : v - 1'b1;
   endfunction

   function automatic logic [15:0] cap16(logic [CB-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
   endfunction

   eng_state_type        state_ff, state_in;
   logic [HASH_BITS-1:0] clr_ff, clr_in;
   func_type             func_ff;
   logic [31:0]          uid_ff, old_ff;
   logic [HASH_BITS-1:0] bkt_a_ff, bkt_b_ff;
   logic [RW-1:0]        row_a_ff, row_b_ff;
   logic                 out_valid_ff;
   status_type           out_status_ff;
   logic [15:0]          out_ref_ff, out_proc_ff;

   logic                 rd_en, wr_en, out_set;
   logic [HASH_BITS-1:0] rd_addr, wr_addr;
   logic [RW-1:0]        rd_data, wr_data, init_row;

   logic                 hit_a, hit_b, has_free, need2;
   logic [WB-1:0]        idx_a, idx_b, free_idx;
   logic [RW-1:0]        new_a, new_b, row_x, row_y;
   logic [CB-1:0]        r_new, p_new;
   status_type           st;
   logic [CB-1:0]        o_ref, o_proc;

   rchash_ram #(
      .WIDTH (RW),
      .DEPTH (BUCKETS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign init_row = ent_set('0, '0, 1'b1, 32'd0, CB'(1), CB'(1));

   // way search: lowest matching way and lowest free way
   always_comb begin
      hit_a    = 1'b0;
      hit_b    = 1'b0;
      has_free = 1'b0;
      idx_a    = '0;
      idx_b    = '0;
      free_idx = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (ent_valid(row_a_ff, WB'(w)) && ent_id(row_a_ff, WB'(w)) == uid_ff) begin
            hit_a = 1'b1;
            idx_a = WB'(w);
         end
         if (ent_valid(row_b_ff, WB'(w)) && ent_id(row_b_ff, WB'(w)) == old_ff) begin
            hit_b = 1'b1;
            idx_b = WB'(w);
         end
         if (!ent_valid(row_a_ff, WB'(w))) begin
            has_free = 1'b1;
            free_idx = WB'(w);
         end
      end
   end

   // row update and result
   always_comb begin
      new_a  = row_a_ff;
      new_b  = row_b_ff;
      row_x  = row_a_ff;
      row_y  = row_b_ff;
      r_new  = '0;
      p_new  = '0;
      need2  = 1'b0;
      st     = STAT_ABSENT;
      o_ref  = '0;
      o_proc = '0;
      unique case (func_ff)
         FN_FIND, FN_ALLOC: begin
            if (hit_a) begin
               r_new  = inc_sat(ent_ref(row_a_ff, idx_a));
               new_a  = ent_set(row_a_ff, idx_a, 1'b1, uid_ff, r_new,
                                ent_proc(row_a_ff, idx_a));
               st     = STAT_FOUND;
               o_ref  = r_new;
               o_proc = ent_proc(row_a_ff, idx_a);
            end else if (func_ff == FN_ALLOC) begin
               if (has_free) begin
                  new_a = ent_set(row_a_ff, free_idx, 1'b1, uid_ff, CB'(1), '0);
                  st    = STAT_INSERTED;
                  o_ref = CB'(1);
               end else begin
                  st = STAT_FULL;
               end
            end
         end
         FN_FREE: begin
            if (hit_a) begin
               r_new = dec_sat(ent_ref(row_a_ff, idx_a));
               if (r_new == '0) begin
                  new_a = ent_set(row_a_ff, idx_a, 1'b0, '0, '0, '0);
                  st    = STAT_REMOVED;
               end else begin
                  new_a  = ent_set(row_a_ff, idx_a, 1'b1, uid_ff, r_new,
                                   ent_proc(row_a_ff, idx_a));
                  st     = STAT_HELD;
                  o_ref  = r_new;
                  o_proc = ent_proc(row_a_ff, idx_a);
               end
            end
         end
         FN_SWITCH: begin
            if (hit_a && hit_b) begin
               row_x = ent_set(row_a_ff, idx_a, 1'b1, uid_ff, ent_ref(row_a_ff, idx_a),
                               inc_sat(ent_proc(row_a_ff, idx_a)));
               row_y = (bkt_a_ff == bkt_b_ff) ? row_x : row_b_ff;
               p_new = dec_sat(ent_proc(row_y, idx_b));
               r_new = dec_sat(ent_ref(row_y, idx_b));
               if (r_new == '0) begin
                  row_y = ent_set(row_y, idx_b, 1'b0, '0, '0, '0);
               end else begin
                  row_y = ent_set(row_y, idx_b, 1'b1, old_ff, r_new, p_new);
               end
               if (bkt_a_ff == bkt_b_ff) begin
                  new_a = row_y;
               end else begin
                  new_a = row_x;
                  new_b = row_y;
                  need2 = 1'b1;
               end
               if (bkt_a_ff == bkt_b_ff && idx_a == idx_b && r_new == '0) begin
                  st = STAT_REMOVED;
               end else begin
                  st     = STAT_FOUND;
                  o_ref  = ent_ref(new_a, idx_a);
                  o_proc = ent_proc(new_a, idx_a);
               end
            end else if (hit_a) begin
               o_ref  = ent_ref(row_a_ff, idx_a);
               o_proc = ent_proc(row_a_ff, idx_a);
            end
         end
         default: begin
            st = STAT_ABSENT;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               state_in = ST_CAP1;
            end
         end
         ST_CAP1: begin
            state_in = (func_ff == FN_SWITCH) ? ST_CAP2 : ST_EXEC;
         end
         ST_CAP2: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!out_valid_ff) begin
               state_in = need2 ? ST_EXEC2 : ST_IDLE;
            end
         end
         ST_EXEC2: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      item_take = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = item_bkt_new;
      wr_en     = 1'b0;
      wr_addr   = bkt_a_ff;
      wr_data   = new_a;
      out_set   = 1'b0;
      clearing  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
            wr_en    = 1'b1;
            wr_addr  = clr_ff;
            wr_data  = (clr_ff == '0) ? init_row : '0;
         end
         ST_IDLE: begin
            item_take = item_valid;
            rd_en     = item_valid;
         end
         ST_CAP1: begin
            rd_en   = 1'b1;
            rd_addr = bkt_b_ff;
         end
         ST_CAP2: begin
         end
         ST_EXEC: begin
            wr_en   = ~out_valid_ff;
            out_set = ~out_valid_ff;
         end
         ST_EXEC2: begin
            wr_en   = 1'b1;
            wr_addr = bkt_b_ff;
            wr_data = new_b;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (out_set) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         func_ff  <= item_func;
         uid_ff   <= item_uid;
         old_ff   <= item_old_uid;
         bkt_a_ff <= item_bkt_new;
         bkt_b_ff <= item_bkt_old;
      end
      if (state_ff == ST_CAP1) begin
         row_a_ff <= rd_data;
      end
      if (state_ff == ST_CAP2) begin
         row_b_ff <= rd_data;
      end
      if (out_set) begin
         out_status_ff <= st;
         out_ref_ff    <= cap16(o_ref);
         out_proc_ff   <= cap16(o_proc);
      end
   end

   assign rsp_empty         = ~out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_ref_count     = out_ref_ff;
   assign rsp_process_count = out_proc_ff;

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      item_take |-> state_ff == ST_IDLE && !clearing)
      else $error("item taken outside idle");

   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !out_valid_ff)
      else $error("result present during clearing pass");

   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      out_set && st == STAT_REMOVED |=> rsp_ref_count == 16'd0 && rsp_process_count == 16'd0)
      else $error("removed entry reports nonzero counts");

   a_exec2_after_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC2 |-> $past(state_ff) == ST_EXEC && func_ff == FN_SWITCH)
      else $error("second write without switch");

endmodule

// ----- hw/rtl/refcounted_uid_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_uid_hash_table: reference-counted user table
// Set-associative table of user records with find, alloc, free and switch.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+------------------
//  request   | req_func, req_uid, req_old_uid               | req_push / req_full
//  response  | rsp_status, rsp_ref_count, rsp_process_count | rsp_pop / rsp_empty
//
// After reset a clearing pass writes every bucket row, one row a cycle;
// req_full stays high during it.
// A request passes through the engine as read row, capture, update/write;
// a switch adds a second row read for old_uid, plus a second write when
// both IDs are found and hash to different buckets. The row RAM's single
// read port with registered read data sets this.
// A two-beat request queue lets new beats land while the engine works or a
// response waits; the engine holds a finished response until it is popped and
// stalls in the update step while the previous response is still waiting.
//
module refcounted_uid_hash_table
   import rchash_pkg::*;
#(
   parameter int HASH_BITS  = 8,
   parameter int WAYS       = 4,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_uid,
   input  logic [31:0] req_old_uid,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_ref_count,
   output logic [15:0] rsp_process_count
);

   logic                 fq_full, eng_clearing;
   logic                 item_valid, item_take;
   func_type             item_func;
   logic [31:0]          item_uid, item_old_uid;
   logic [HASH_BITS-1:0] item_bkt_new, item_bkt_old;

   // hold off requests during the clearing pass
   assign req_full = fq_full | eng_clearing;

   rchash_front #(
      .HASH_BITS (HASH_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push & ~req_full),
      .func         (req_func),
      .uid          (req_uid),
      .old_uid      (req_old_uid),
      .full         (fq_full),
      .item_valid   (item_valid),
      .item_take    (item_take),
      .item_func    (item_func),
      .item_uid     (item_uid),
      .item_old_uid (item_old_uid),
      .item_bkt_new (item_bkt_new),
      .item_bkt_old (item_bkt_old)
   );

   rchash_back #(
      .HASH_BITS  (HASH_BITS),
      .WAYS       (WAYS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .item_take         (item_take),
      .item_func         (item_func),
      .item_uid          (item_uid),
      .item_old_uid      (item_old_uid),
      .item_bkt_new      (item_bkt_new),
      .item_bkt_old      (item_bkt_old),
      .clearing          (eng_clearing),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_status        (rsp_status),
      .rsp_ref_count     (rsp_ref_count),
      .rsp_process_count (rsp_process_count)
   );

endmodule
